// File: src/obstacle_avoid_drive_select_top_assert.svh
// Assertion macros shared by the RTL. Empty when SYNTHESIS is defined.
`ifndef OBSTACLE_AVOID_DRIVE_SELECT_TOP_ASSERT_SVH
`define OBSTACLE_AVOID_DRIVE_SELECT_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every rising edge outside reset.
`define OADS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define OADS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define OADS_ASSERT(label, clk, rst, prop, msg)
`define OADS_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// File: src/oads_pkg.sv
`timescale 1ns / 1ps

package oads_pkg;

  typedef enum logic [2:0] {
    DRV_STOP  = 3'd0,
    DRV_FWD   = 3'd1,
    DRV_BWD   = 3'd2,
    DRV_LEFT  = 3'd3,
    DRV_RIGHT = 3'd4
  } drive_t;

  localparam logic [2:0] CMD_F = 3'd1;
  localparam logic [2:0] CMD_B = 3'd2;
  localparam logic [2:0] CMD_L = 3'd3;
  localparam logic [2:0] CMD_R = 3'd4;
  localparam logic [2:0] CMD_S = 3'd5;

  localparam logic [6:0] NEAR_THRESHOLD_RESET = 7'd15;

  // Register byte addresses
  localparam logic [2:0] ADDR_REMOTE_MODE    = 3'd0;
  localparam logic [2:0] ADDR_NEAR_THRESHOLD = 3'd4;

  typedef struct packed {
    logic       edge_front_left;
    logic       edge_front_right;
    logic       edge_back_left;
    logic       edge_back_right;
    logic [6:0] dist_front_left;
    logic [6:0] dist_front_center;
    logic [6:0] dist_front_right;
    logic [6:0] dist_back_right;
    logic [6:0] dist_back_center;
    logic [6:0] dist_back_left;
    logic [2:0] command;
  } req_t;

  typedef struct packed {
    logic [2:0] drive;
    logic [3:0] motor_pins;
    logic       heading_back;
  } res_t;

  // Decision state carried from tick to tick
  typedef struct packed {
    drive_t drive;
    logic   heading;
  } state_t;

  typedef struct packed {
    logic       remote_mode;
    logic [6:0] near_threshold;
  } cfg_t;

  // Motor driver levels: bit0 A1A, bit1 A1B, bit2 B1A, bit3 B1B
  function automatic logic [3:0] motor_pins_of(input logic [2:0] drv);
    logic [3:0] pins;
    case (drv)
      DRV_FWD:   pins = 4'hA;
      DRV_BWD:   pins = 4'h5;
      DRV_LEFT:  pins = 4'h9;
      DRV_RIGHT: pins = 4'h6;
      default:   pins = 4'h0;
    endcase
    return pins;
  endfunction

endpackage

// File: src/oads_decide.sv
`timescale 1ns / 1ps

module oads_decide import oads_pkg::*; (
  input  req_t   req,
  input  cfg_t   cfg,
  input  state_t cur,
  output state_t nxt
);

  logic n_fl, n_fc, n_fr, n_br, n_bc, n_bl;
  logic c_fl, c_fc, c_fr, c_br, c_bc, c_bl;
  logic efl, efr, ebl, ebr;
  logic front_edges, back_edges;
  logic safety;
  logic use_front, use_back;

  assign efl = req.edge_front_left;
  assign efr = req.edge_front_right;
  assign ebl = req.edge_back_left;
  assign ebr = req.edge_back_right;

  // Strict compares: a distance equal to the threshold is neither near nor clear
  assign n_fl = req.dist_front_left   < cfg.near_threshold;
  assign n_fc = req.dist_front_center < cfg.near_threshold;
  assign n_fr = req.dist_front_right  < cfg.near_threshold;
  assign n_br = req.dist_back_right   < cfg.near_threshold;
  assign n_bc = req.dist_back_center  < cfg.near_threshold;
  assign n_bl = req.dist_back_left    < cfg.near_threshold;
  assign c_fl = req.dist_front_left   > cfg.near_threshold;
  assign c_fc = req.dist_front_center > cfg.near_threshold;
  assign c_fr = req.dist_front_right  > cfg.near_threshold;
  assign c_br = req.dist_back_right   > cfg.near_threshold;
  assign c_bc = req.dist_back_center  > cfg.near_threshold;
  assign c_bl = req.dist_back_left    > cfg.near_threshold;

  assign front_edges = !efr && !efl;
  assign back_edges  = !ebr && !ebl;

  assign safety = (front_edges && back_edges) || (n_fc && n_bc) ||
                  (n_fc && back_edges) || (n_bc && front_edges);

  assign use_front = cfg.remote_mode ? (req.command == CMD_F) : !cur.heading;
  assign use_back  = cfg.remote_mode ? (req.command == CMD_B) :  cur.heading;

  always_comb begin
    nxt = cur;
    if (safety) begin
      nxt.drive = DRV_STOP;
      if (!cfg.remote_mode) begin
        nxt.heading = 1'b0;
      end
    end else if (use_front) begin
      if ((!efr && efl) || (n_fr && c_fl)) begin
        nxt.drive = DRV_LEFT;
      end else if ((!efl && efr) || (c_fr && n_fl)) begin
        nxt.drive = DRV_RIGHT;
      end else if (efr && efl && c_fr && c_fl && c_fc) begin
        nxt.drive = DRV_FWD;
      end else if (front_edges || n_fc) begin
        nxt.drive = DRV_BWD;
        if (!cfg.remote_mode) begin
          nxt.heading = 1'b1;
        end
      end
    end else if (use_back) begin
      if ((!ebr && ebl) || (n_br && c_bl)) begin
        nxt.drive = DRV_RIGHT;
      end else if ((!ebl && ebr) || (c_br && n_bl)) begin
        nxt.drive = DRV_LEFT;
      end else if (ebr && ebl && c_br && c_bl && c_bc) begin
        nxt.drive = DRV_BWD;
      end else if (back_edges || n_bc) begin
        nxt.drive = DRV_FWD;
        if (!cfg.remote_mode) begin
          nxt.heading = 1'b0;
        end
      end
    end else if (cfg.remote_mode) begin
      case (req.command)
        CMD_L: nxt.drive = DRV_LEFT;
        CMD_R: nxt.drive = DRV_RIGHT;
        CMD_S: begin
          if (!efr || n_fr || !ebl || n_bl) begin
            nxt.drive = DRV_LEFT;
          end else if (!efl || n_fl || !ebr || n_br) begin
            nxt.drive = DRV_RIGHT;
          end else if (front_edges || n_fc) begin
            nxt.drive = DRV_BWD;
          end else if (back_edges || n_bc) begin
            nxt.drive = DRV_FWD;
          end else begin
            nxt.drive = DRV_STOP;
          end
        end
        default: nxt = cur; // unknown command holds the last drive
      endcase
    end
  end

endmodule

// File: src/obstacle_avoid_drive_select_top.sv
`timescale 1ns / 1ps
// Drive selection for a two-motor rover. Each accepted request carries one
// snapshot of the floor-edge flags, six distances and a remote command, and
// yields exactly one result: drive code, motor driver levels and heading.
// A request is registered, decided combinationally against the held drive and
// heading, and the result lands in an output register, so one request per
// clock is taken while the result is not stalled. The decision
// depends on the previous request's drive and heading, which are updated as
// each request moves into the output register. Registers: remote_mode at
// byte 0, near_threshold at byte 4; write them only while no request is in
// flight.
`include "obstacle_avoid_drive_select_top_assert.svh"

module obstacle_avoid_drive_select_top import oads_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req_data,
  output logic        res_valid,
  input  logic        res_stall,
  output res_t        res_data
);

  cfg_t   cfg;
  state_t state;
  state_t state_next;
  req_t   hold;
  logic   hold_valid;
  logic   out_ready;
  logic   advance;
  logic   cfg_write;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.remote_mode    <= 1'b0;
      cfg.near_threshold <= NEAR_THRESHOLD_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == ADDR_NEAR_THRESHOLD[2]) begin
        cfg.near_threshold <= pwdata[6:0];
      end else begin
        cfg.remote_mode <= pwdata[0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == ADDR_NEAR_THRESHOLD[2]) begin
      prdata = {25'd0, cfg.near_threshold};
    end else begin
      prdata = {31'd0, cfg.remote_mode};
    end
  end

  // Two-stage flow: input register, then result register
  assign out_ready = !res_valid || !res_stall;
  assign advance   = hold_valid && out_ready;
  assign req_stall = hold_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!req_stall) begin
      hold_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      hold <= req_data;
    end
  end

  oads_decide u_decide (
    .req (hold),
    .cfg (cfg),
    .cur (state),
    .nxt (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.drive   <= DRV_STOP;
      state.heading <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (advance) begin
        state     <= state_next;
        res_valid <= 1'b1;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_data.drive        <= state_next.drive;
      res_data.motor_pins   <= motor_pins_of(state_next.drive);
      res_data.heading_back <= state_next.heading;
    end
  end

  `OADS_ASSERT(a_pins_match, clk, rst, res_valid |-> res_data.motor_pins == motor_pins_of(res_data.drive), "motor pins disagree with drive")
  `OADS_ASSERT(a_heading_out, clk, rst, res_valid |-> res_data.heading_back == state.heading, "result heading differs from held heading")
  `OADS_ASSERT(a_state_hold, clk, rst, !advance |=> $stable(state), "decision state moved without a request")
  `OADS_ASSERT(a_remote_heading, clk, rst, cfg.remote_mode |=> $stable(state.heading), "heading changed in remote mode")
  `OADS_ASSERT(a_no_drop, clk, rst, req_stall |=> hold_valid, "held request lost while stalled")

endmodule
